// ===== hdl/tce_pkg.sv =====
// Package for threshold_cross_erosion: register indexes, reset values,
// result and pipeline-stage structs. No dependencies.
`default_nettype none

package tce_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD    = 2'd2;

   // Field widths
   localparam int unsigned PIXEL_BITS  = 10;
   localparam int unsigned FWIDTH_BITS = 11;
   localparam int unsigned FHEIGHT_BITS = 16;

   // Register reset values
   localparam logic [FWIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd19;
   localparam logic [FHEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd15;
   localparam logic [PIXEL_BITS-1:0]   THRESHOLD_RESET    = 10'd700;

   // Line store sizing
   localparam int unsigned MAX_WIDTH_DEFAULT = 1024;

   // One result item
   typedef struct packed {
      logic eroded;
      logic last_of_frame;
   } tce_result_type;

   // Per-item control carried from the accept cycle into the merge stage
   typedef struct packed {
      logic emit;      // item produces a result
      logic last;      // result is the last of the frame
      logic use_left;  // left neighbour is interior
      logic use_right; // right neighbour is interior
      logic use_up;    // upper neighbour is interior
      logic use_down;  // lower neighbour (this item) is interior
      logic par;       // parity of the current row
      logic pix_bit;   // binarized pixel
   } tce_stage_type;

endpackage

`default_nettype wire

// ===== hdl/tce_if.sv =====
// Stream interfaces for threshold_cross_erosion: pixel request channel and
// eroded result channel. Depends on tce_pkg for field widths.
`default_nettype none

interface tce_req_if;
   logic                           valid;
   logic                           ready;
   logic [tce_pkg::PIXEL_BITS-1:0] pixel;
   logic                           frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface tce_rsp_if;
   logic valid;
   logic ready;
   logic eroded;
   logic last_of_frame;

   modport source (output valid, output eroded, output last_of_frame, input ready);
   modport sink (input valid, input eroded, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== hdl/tce_ram.sv =====
// Generic RAM: one write port, two registered read ports (old data on a
// same-address write). No dependencies.
`default_nettype none

module tce_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== hdl/tce_out_queue.sv =====
// Two-entry result queue between the merge stage and the result channel.
// Depends on tce_pkg for the result struct.
`default_nettype none

module tce_out_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire tce_pkg::tce_result_type push_data,
   input  wire                          pop,
   output tce_pkg::tce_result_type      head,
   output logic [1:0]                   level
);

   tce_pkg::tce_result_type slot0_ff, slot0_in;
   tce_pkg::tce_result_type slot1_ff, slot1_in;
   logic [1:0]              level_ff, level_in;
   logic [1:0]              put_pos;

   // Shift on pop, write the new item behind what remains
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      put_pos  = level_ff - {1'b0, pop};
      level_in = level_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (put_pos == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head  = slot0_ff;
   assign level = level_ff;

endmodule

`default_nettype wire

// ===== hdl/threshold_cross_erosion.sv =====
// Top level of threshold_cross_erosion: counters, binarizer, line store
// read-modify-write and cross erosion. Depends on tce_pkg, tce_if,
// tce_ram and tce_out_queue.
//
//   channel  direction  handshake          payload
//   req_ch   in         valid/ready        pixel[9:0], frame_start
//   rsp_ch   out        valid/ready        eroded, last_of_frame
//   csr_*    in         csr_we (no ready)  csr_index[1:0], csr_wdata[15:0]
//
// One pixel per clock sustained while the result queue has room. An item
// is first accepted (line store read issued at columns c and c+1), then
// passes the merge stage (read data back, result formed, word written
// back at column c). A two-entry result queue absorbs output stalls;
// req_ch.ready drops only when the queue cannot take the result of the
// next item. Reset clears counters, configuration registers and valid
// state; the line store holds no reset value and needs no clearing pass.
`default_nettype none

module threshold_cross_erosion #(
   parameter int unsigned MAX_WIDTH = tce_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   tce_req_if.sink                             req_ch,
   tce_rsp_if.source                           rsp_ch,
   input  wire                                 csr_we,
   input  wire [tce_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [tce_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int unsigned AW = $clog2(MAX_WIDTH);       // column address
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);   // holds MAX_WIDTH
   localparam int unsigned EW = (WW > tce_pkg::FWIDTH_BITS) ? WW : tce_pkg::FWIDTH_BITS;
   localparam int unsigned CX = WW + 1;                  // column arithmetic
   localparam int unsigned RX = tce_pkg::FHEIGHT_BITS + 1;

   // Configuration registers
   logic [tce_pkg::FWIDTH_BITS-1:0]  frame_width_ff;
   logic [tce_pkg::FHEIGHT_BITS-1:0] frame_height_ff;
   logic [tce_pkg::PIXEL_BITS-1:0]   threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= tce_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= tce_pkg::FRAME_HEIGHT_RESET;
         threshold_ff    <= tce_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tce_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[tce_pkg::FWIDTH_BITS-1:0];
            end
            tce_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata;
            end
            tce_pkg::REG_THRESHOLD: begin
               threshold_ff <= csr_wdata[tce_pkg::PIXEL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective frame size
   logic [EW-1:0] fw_ext;
   logic [EW-1:0] w_ext;
   logic [CX-1:0] w_x;
   logic [RX-1:0] h_x;

   always_comb begin
      fw_ext = EW'(frame_width_ff);
      if (fw_ext < EW'(3)) begin
         w_ext = EW'(3);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         w_ext = EW'(MAX_WIDTH);
      end else begin
         w_ext = fw_ext;
      end
      w_x = CX'(w_ext[WW-1:0]);
      h_x = (frame_height_ff < 16'd3) ? RX'(3) : RX'(frame_height_ff);
   end

   // Position counters and per-item decode
   logic [AW-1:0]                    col_ff, col_in;
   logic [tce_pkg::FHEIGHT_BITS-1:0] row_ff, row_in;
   logic [CX-1:0]                    c0, c1;
   logic [RX-1:0]                    r0, r1;
   tce_pkg::tce_stage_type           stage_in;
   logic [AW-1:0]                    rd_addr_a, rd_addr_b;
   logic                             acc;

   assign acc = req_ch.valid && req_ch.ready;

   always_comb begin
      if (req_ch.frame_start) begin
         c0 = '0;
         r0 = '0;
      end else begin
         c0 = CX'(col_ff);
         r0 = RX'(row_ff);
         if (c0 >= w_x) begin
            c0 = '0;
            r0 = r0 + RX'(1);
         end
         if (r0 >= h_x) begin
            r0 = '0;
         end
      end

      stage_in.emit      = (r0 >= RX'(2)) && (c0 >= CX'(1)) && (c0 + CX'(2) <= w_x);
      stage_in.last      = (r0 + RX'(1) == h_x) && (c0 + CX'(2) == w_x);
      stage_in.use_left  = c0 >= CX'(2);
      stage_in.use_right = (c0 + CX'(2)) < w_x;
      stage_in.use_up    = r0 >= RX'(3);
      stage_in.use_down  = (r0 + RX'(1)) < h_x;
      stage_in.par       = r0[0];
      stage_in.pix_bit   = req_ch.pixel >= threshold_ff;

      // Advance to the next raster position
      c1 = c0 + CX'(1);
      r1 = r0;
      if (c1 >= w_x) begin
         c1 = '0;
         r1 = r0 + RX'(1);
         if (r1 >= h_x) begin
            r1 = '0;
         end
      end
      col_in = c1[AW-1:0];
      row_in = r1[tce_pkg::FHEIGHT_BITS-1:0];

      rd_addr_b = c0[AW-1:0];
      rd_addr_a = AW'(c0 + CX'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Merge stage registers
   logic                   s1_valid_ff;
   tce_pkg::tce_stage_type s1_ff;
   logic [AW-1:0]          s1_col_ff;
   logic                   fwd_a_ff, fwd_b_ff;
   logic [1:0]             fwd_word_ff;
   logic                   left_ff;

   // Line store: one 2-bit word per column, one bit per row parity
   logic [1:0] rd_data_a, rd_data_b;
   logic [1:0] word_a, word_b, wr_word;
   logic       center, right_bit, up_bit, eroded_v;

   tce_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_col_ff),
      .wr_data   (wr_word),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Read data with forwarding of the write that overlapped the read
   always_comb begin
      word_a    = fwd_a_ff ? fwd_word_ff : rd_data_a;
      word_b    = fwd_b_ff ? fwd_word_ff : rd_data_b;
      center    = word_b[~s1_ff.par];
      up_bit    = word_b[s1_ff.par];
      right_bit = word_a[~s1_ff.par];
      wr_word   = s1_ff.par ? {s1_ff.pix_bit, word_b[0]} : {word_b[1], s1_ff.pix_bit};
      eroded_v  = center
                & (s1_ff.use_left  ? left_ff    : 1'b1)
                & (s1_ff.use_right ? right_bit  : 1'b1)
                & (s1_ff.use_up    ? up_bit     : 1'b1)
                & (s1_ff.use_down  ? s1_ff.pix_bit : 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= acc;
      end
      if (acc) begin
         s1_ff       <= stage_in;
         s1_col_ff   <= rd_addr_b;
         fwd_a_ff    <= s1_valid_ff && (s1_col_ff == rd_addr_a);
         fwd_b_ff    <= s1_valid_ff && (s1_col_ff == rd_addr_b);
         fwd_word_ff <= wr_word;
      end
      // The centre bit (row above the item) at this column is the left neighbour of the next item
      if (s1_valid_ff) begin
         left_ff <= center;
      end
   end

   // Result queue and flow control
   tce_pkg::tce_result_type push_data, head;
   logic [1:0]              q_level;
   logic                    push, pop;
   logic [2:0]              fill;

   assign push                 = s1_valid_ff && s1_ff.emit;
   assign push_data.eroded     = eroded_v;
   assign push_data.last_of_frame = s1_ff.last;
   assign pop                  = rsp_ch.valid && rsp_ch.ready;
   assign fill                 = {1'b0, q_level} + {2'b00, push} - {2'b00, pop};
   assign req_ch.ready         = fill <= 3'd1;

   tce_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .level     (q_level)
   );

   assign rsp_ch.valid         = q_level != 2'd0;
   assign rsp_ch.eroded        = head.eroded;
   assign rsp_ch.last_of_frame = head.last_of_frame;

   // A result never arrives at a full queue that is not being drained
   assert property (@(posedge clock) disable iff (reset)
      push |-> (q_level != 2'd2) || pop)
      else $error("result pushed into a full queue");

   // Every accepted item spends the next cycle in the merge stage
   assert property (@(posedge clock) disable iff (reset)
      acc |=> s1_valid_ff)
      else $error("accepted item missing from merge stage");

   // A frame start always lands on column zero of an even row
   assert property (@(posedge clock) disable iff (reset)
      acc && req_ch.frame_start |=> (s1_col_ff == '0) && !s1_ff.par && !s1_ff.emit)
      else $error("frame start not at row zero, column zero");

endmodule

`default_nettype wire
